### src/itad_pkg.sv
// itad_pkg: shared types, constants and helpers for the integer to ascii block
// no dependencies; imported by every module under src
package itad_pkg;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned RADIX_W  = 6;
  localparam int unsigned CHAR_W   = 7;
  localparam int unsigned LEN_W    = 6;
  localparam int unsigned STEP_W   = 4;  // quotient bits resolved per divider cycle

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
  localparam logic [RADIX_W-1:0] DECIMAL   = 6'd10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_UPPER = 7'h41;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [RADIX_W-1:0]        radix;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
    logic [LEN_W-1:0]  text_length;
  } out_item_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV_GO,
    B_DIV_WAIT,
    B_SIGN,
    B_READ,
    B_SHOW
  } back_state_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d > 6'd9) begin
      c = CHAR_UPPER + CHAR_W'(d - 6'd10);
    end else begin
      c = CHAR_ZERO + CHAR_W'(d);
    end
    return c;
  endfunction

endpackage

### src/itad_front.sv
// itad_front: accepts words, clamps the radix, takes the decimal sign apart
// and holds up to two classified words for the back part; uses itad_pkg
module itad_front #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  itad_pkg::in_item_t         operand,
  output logic                       q_valid,
  output logic [VALUE_BITS-1:0]      q_mag,
  output logic [itad_pkg::RADIX_W-1:0] q_radix,
  output logic                       q_neg,
  input  logic                       q_take
);
  import itad_pkg::*;

  localparam int unsigned DEPTH = 2;

  logic [VALUE_BITS-1:0] v;
  logic [VALUE_BITS-1:0] mag;
  logic [RADIX_W-1:0]    radix;
  logic                  neg;

  logic [VALUE_BITS-1:0] mag_q   [DEPTH];
  logic [RADIX_W-1:0]    radix_q [DEPTH];
  logic                  neg_q   [DEPTH];
  logic                  wr_ptr;
  logic                  rd_ptr;
  logic [1:0]            count;
  logic                  do_push;
  logic                  do_pop;

  generate
    if (VALUE_BITS > VALUE_W) begin : g_ext
      assign v = {{(VALUE_BITS-VALUE_W){operand.value[VALUE_W-1]}}, operand.value};
    end else begin : g_trunc
      assign v = operand.value[VALUE_BITS-1:0];
    end
  endgenerate

  always_comb begin
    if (operand.radix < RADIX_MIN) begin
      radix = RADIX_MIN;
    end else if (operand.radix > RADIX_MAX) begin
      radix = RADIX_MAX;
    end else begin
      radix = operand.radix;
    end
    neg = v[VALUE_BITS-1] && (radix == DECIMAL);
    // most negative value negates to itself and is then read as unsigned
    mag = neg ? (VALUE_BITS'(0) - v) : v;
  end

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign do_push = push && !full;
  assign do_pop  = q_take && q_valid;

  assign q_mag   = mag_q[rd_ptr];
  assign q_radix = radix_q[rd_ptr];
  assign q_neg   = neg_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mag_q[wr_ptr]   <= mag;
      radix_q[wr_ptr] <= radix;
      neg_q[wr_ptr]   <= neg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

### src/itad_divider.sv
// itad_divider: digit-serial unsigned divide by a small radix, four quotient
// bits per cycle with a narrow remainder; uses itad_pkg
module itad_divider #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [VALUE_BITS-1:0]        dividend,
  input  logic [itad_pkg::RADIX_W-1:0] divisor,
  output logic                         done,
  output logic [VALUE_BITS-1:0]        quotient,
  output logic [itad_pkg::RADIX_W-1:0] remainder
);
  import itad_pkg::*;

  localparam int unsigned STEPS = (VALUE_BITS + STEP_W - 1) / STEP_W;
  localparam int unsigned PAD   = STEPS * STEP_W;
  localparam int unsigned CNT_W = $clog2(STEPS + 1);

  logic [PAD-1:0]     num;
  logic [PAD-1:0]     quot;
  logic [RADIX_W-1:0] rem;
  logic [RADIX_W-1:0] dsr;
  logic [CNT_W-1:0]   cnt;
  logic               busy;

  logic [PAD-1:0]     num_next;
  logic [PAD-1:0]     quot_next;
  logic [RADIX_W-1:0] rem_next;

  // restoring steps; remainder stays below the radix so 7 bits cover the trial
  always_comb begin
    logic [RADIX_W:0] trial;
    num_next  = num;
    quot_next = quot;
    rem_next  = rem;
    for (int i = 0; i < STEP_W; i++) begin
      trial    = {rem_next, num_next[PAD-1]};
      num_next = {num_next[PAD-2:0], 1'b0};
      if (trial >= {1'b0, dsr}) begin
        rem_next  = RADIX_W'(trial - {1'b0, dsr});
        quot_next = {quot_next[PAD-2:0], 1'b1};
      end else begin
        rem_next  = trial[RADIX_W-1:0];
        quot_next = {quot_next[PAD-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num  <= PAD'(dividend);
      quot <= '0;
      rem  <= '0;
      dsr  <= divisor;
    end else if (busy) begin
      num  <= num_next;
      quot <= quot_next;
      rem  <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quot[VALUE_BITS-1:0];
  assign remainder = rem;

endmodule

### src/itad_back.sv
// itad_back: sequencer that drives the divider, keeps digits in a small
// memory and plays them out most significant first; uses itad_pkg
module itad_back #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  logic [VALUE_BITS-1:0]        q_mag,
  input  logic [itad_pkg::RADIX_W-1:0] q_radix,
  input  logic                         q_neg,
  output logic                         q_take,
  output logic                         div_start,
  output logic [VALUE_BITS-1:0]        div_dividend,
  output logic [itad_pkg::RADIX_W-1:0] div_divisor,
  input  logic                         div_done,
  input  logic [VALUE_BITS-1:0]        div_quot,
  input  logic [itad_pkg::RADIX_W-1:0] div_rem,
  output logic                         empty,
  input  logic                         pop,
  output itad_pkg::out_item_t          result
);
  import itad_pkg::*;

  localparam int unsigned IDX_W = $clog2(VALUE_BITS);
  localparam int unsigned CNT_W = $clog2(VALUE_BITS + 1);
  localparam int unsigned LFT_W = CNT_W + 1;

  back_state_t        state;
  back_state_t        state_next;

  logic [VALUE_BITS-1:0] mag;
  logic [RADIX_W-1:0]    radix;
  logic                  neg;
  logic [CNT_W-1:0]      cnt;
  logic [IDX_W-1:0]      rd_idx;
  logic [LFT_W-1:0]      left;
  logic [LEN_W-1:0]      total;
  logic [RADIX_W-1:0]    rd_data;
  logic [RADIX_W-1:0]    store [VALUE_BITS];

  logic                  out_valid;
  out_item_t             out_item;
  logic                  out_free;
  logic                  load;
  out_item_t             load_item;
  logic                  wr_en;
  logic                  take;
  logic                  finish;
  logic                  emit;

  assign out_free     = !out_valid || pop;
  assign empty        = !out_valid;
  assign result       = out_item;
  assign div_dividend = mag;
  assign div_divisor  = radix;

  always_comb begin
    state_next = state;
    take       = 1'b0;
    div_start  = 1'b0;
    wr_en      = 1'b0;
    finish     = 1'b0;
    load       = 1'b0;
    emit       = 1'b0;
    load_item  = '{character: CHAR_MINUS, last: (left == LFT_W'(1)), text_length: total};
    unique case (state)
      B_IDLE: begin
        if (q_valid) begin
          take       = 1'b1;
          state_next = B_DIV_GO;
        end
      end
      B_DIV_GO: begin
        div_start  = 1'b1;
        state_next = B_DIV_WAIT;
      end
      B_DIV_WAIT: begin
        if (div_done) begin
          wr_en = 1'b1;
          if (div_quot == '0) begin
            finish     = 1'b1;
            state_next = neg ? B_SIGN : B_READ;
          end else begin
            state_next = B_DIV_GO;
          end
        end
      end
      B_SIGN: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = B_READ;
        end
      end
      B_READ: begin
        state_next = B_SHOW;
      end
      B_SHOW: begin
        load_item.character = digit_char(rd_data);
        if (out_free) begin
          load       = 1'b1;
          emit       = 1'b1;
          state_next = (left == LFT_W'(1)) ? B_IDLE : B_READ;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  assign q_take = take;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // digit memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[cnt[IDX_W-1:0]] <= div_rem;
    end
    rd_data <= store[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (take) begin
      mag   <= q_mag;
      radix <= q_radix;
      neg   <= q_neg;
      cnt   <= '0;
    end
    if (wr_en) begin
      mag <= div_quot;
      cnt <= cnt + CNT_W'(1);
    end
    if (finish) begin
      // digits so far plus the one just written, plus the sign
      left   <= LFT_W'(cnt) + LFT_W'(1) + LFT_W'(neg);
      total  <= LEN_W'(LFT_W'(cnt) + LFT_W'(1) + LFT_W'(neg));
      rd_idx <= cnt[IDX_W-1:0];
    end
    if (load) begin
      left <= left - LFT_W'(1);
    end
    if (emit) begin
      rd_idx <= rd_idx - IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= load_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### src/integer_to_ascii_digits.sv
// integer_to_ascii_digits: top level, joins front, divider and back
// depends on itad_pkg, itad_front, itad_divider, itad_back
//
// Usage:
//   Input queue: drive operand (value, radix) and raise push; a word is taken
//   on a clock edge with push high and full low. Up to two words wait in the
//   front queue while the back part works on the current one.
//   Result queue: while empty is low, result holds the next character of the
//   text, most significant first, with last on the final character and
//   text_length (characters in the string) on every one; pop takes it.
//   A radix outside 2..36 is clamped; in radix 10 a negative value gets '-'.
// Operation:
//   each digit costs one pass of the shared divider; each character then
//   goes through the registered digit memory read, and the sign has its own
//   state. A stalled receiver holds the back part; the front keeps taking words
//   until its queue fills. Reset empties both queues, no clearing pass.
module integer_to_ascii_digits #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  itad_pkg::in_item_t  operand,
  output logic                empty,
  input  logic                pop,
  output itad_pkg::out_item_t result
);
  import itad_pkg::*;

  logic                  q_valid;
  logic [VALUE_BITS-1:0] q_mag;
  logic [RADIX_W-1:0]    q_radix;
  logic                  q_neg;
  logic                  q_take;
  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  logic [RADIX_W-1:0]    div_divisor;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quot;
  logic [RADIX_W-1:0]    div_rem;

  itad_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .operand (operand),
    .q_valid (q_valid),
    .q_mag   (q_mag),
    .q_radix (q_radix),
    .q_neg   (q_neg),
    .q_take  (q_take)
  );

  itad_divider #(.VALUE_BITS(VALUE_BITS)) u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  itad_back #(.VALUE_BITS(VALUE_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_mag        (q_mag),
    .q_radix      (q_radix),
    .q_neg        (q_neg),
    .q_take       (q_take),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_done     (div_done),
    .div_quot     (div_quot),
    .div_rem      (div_rem),
    .empty        (empty),
    .pop          (pop),
    .result       (result)
  );

endmodule

### tb/sv/integer_to_ascii_digits_tb.sv
// integer_to_ascii_digits_tb: self-checking bench for the integer to ascii block
// drives (value, radix) words, predicts the character stream and checks each popped char
// depends on itad_pkg and integer_to_ascii_digits
module integer_to_ascii_digits_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import itad_pkg::*;

  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned RANDOM_WORDS = 340;
  localparam int unsigned TAIL_CYCLES  = 60;

  class text_scoreboard;
    out_item_t   pending[$];
    int unsigned errors;
    int unsigned words;
    int unsigned chars;
    int unsigned negatives;
    int unsigned clamped;

    function void report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endfunction

    // spells one accepted word, most significant character first
    function void note_operand(in_item_t w);
      int unsigned mag;
      int unsigned base;
      int unsigned d;
      logic        neg;
      int unsigned digit_q[$];
      int unsigned total;
      out_item_t   o;
      base = w.radix;
      if (base < RADIX_MIN) base = RADIX_MIN;
      if (base > RADIX_MAX) base = RADIX_MAX;
      if (base != w.radix) clamped++;
      mag = w.value;
      neg = w.value[VALUE_W-1] && (base == DECIMAL);
      // most negative stays 32'h8000_0000, read as unsigned magnitude
      if (neg) mag = -mag;
      do begin
        digit_q.push_back(mag % base);
        mag = mag / base;
      end while (mag != 0);
      total = digit_q.size() + neg;
      words++;
      if (neg) begin
        negatives++;
        o.character   = CHAR_MINUS;
        o.last        = (total == 1);
        o.text_length = LEN_W'(total);
        pending.push_back(o);
      end
      for (int k = digit_q.size() - 1; k >= 0; k--) begin
        d = digit_q[k];
        if (d > 9) o.character = CHAR_UPPER + CHAR_W'(d - 10);
        else o.character = CHAR_ZERO + CHAR_W'(d);
        o.last        = (k == 0);
        o.text_length = LEN_W'(total);
        pending.push_back(o);
      end
    endfunction

    function void check_char(out_item_t got);
      out_item_t exp;
      chars++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected char %h last %b len %0d",
                         got.character, got.last, got.text_length));
        return;
      end
      exp = pending.pop_front();
      if (got.character !== exp.character)
        report($sformatf("char %h, expected %h", got.character, exp.character));
      if (got.last !== exp.last)
        report($sformatf("last %b, expected %b (char %h)", got.last, exp.last, exp.character));
      if (got.text_length !== exp.text_length)
        report($sformatf("length %0d, expected %0d", got.text_length, exp.text_length));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic        full;
  logic        empty;
  in_item_t    operand = '0;
  out_item_t   result;
  logic        tx_steady = 1'b0;
  int unsigned quiet_cycles = 0;

  text_scoreboard sb = new();

  integer_to_ascii_digits DUT (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .operand (operand),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && push && !full) sb.note_operand(operand);
    if (!rst && pop && !empty) sb.check_char(result);
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("stalled for %0d cycles with %0d chars outstanding",
               quiet_cycles, sb.pending.size());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_operand(input logic [VALUE_W-1:0] v, input logic [RADIX_W-1:0] r);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    operand <= '{value: v, radix: r};
    do @(posedge clk); while (full);
  endtask

  task automatic run_receiver();
    int unsigned gap;
    int unsigned taken;
    taken = 0;
    forever begin
      // every fourth stretch of 60 chars pops back to back
      gap = ((taken / 60) % 4 == 3) ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      taken++;
    end
  endtask

  task automatic send_random_word();
    logic [VALUE_W-1:0] v;
    logic [RADIX_W-1:0] r;
    case ($urandom_range(0, 4))
      0: v = $urandom();
      1: v = $urandom_range(0, 99);
      2: v = -$urandom_range(1, 999);
      3: v = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
                                  : 32'h7FFF_FFFF - $urandom_range(0, 3);
      default: v = $urandom() >> $urandom_range(0, 31);
    endcase
    case ($urandom_range(0, 9))
      0: r = $urandom_range(0, 63);
      1, 2, 3: r = DECIMAL;
      default: r = $urandom_range(RADIX_MIN, RADIX_MAX);
    endcase
    send_operand(v, r);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    fork
      run_receiver();
    join_none

    // zero, signs, extremes, letter digits and clamped bases
    send_operand(32'd0, DECIMAL);
    send_operand(32'd0, RADIX_MIN);
    send_operand(32'd0, RADIX_MAX);
    send_operand(32'd9, DECIMAL);
    send_operand(32'hFFFF_FFFF, DECIMAL);
    send_operand(-32'd123, DECIMAL);
    send_operand(32'h8000_0000, DECIMAL);
    send_operand(32'h7FFF_FFFF, DECIMAL);
    send_operand(32'hFFFF_FFFF, RADIX_MIN);
    send_operand(32'h8000_0000, RADIX_MIN);
    send_operand(32'hFFFF_FFFF, 6'd16);
    send_operand(32'hFFFF_FFFF, RADIX_MAX);
    send_operand(32'd35, RADIX_MAX);
    send_operand(32'd36, RADIX_MAX);
    send_operand(32'd10, 6'd11);
    send_operand(-32'd5, 6'd16);
    send_operand(32'd5, 6'd0);
    send_operand(32'd5, 6'd1);
    send_operand(32'd255, 6'd37);
    send_operand(32'h1234_5678, 6'd63);
    send_operand(32'd1, RADIX_MIN);
    send_operand(32'hDEAD_BEEF, 6'd27);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      tx_steady <= ((i / 45) % 3 == 2);
      send_random_word();
    end
    push <= 1'b0;

    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("converted %0d words into %0d chars, %0d decimal negatives, %0d clamped bases",
             sb.words, sb.chars, sb.negatives, sb.clamped);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
